FILE: hw/rtl/heartbeat_node_presence_table_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef HEARTBEAT_NODE_PRESENCE_TABLE_TOP_MACROS_SVH
`define HEARTBEAT_NODE_PRESENCE_TABLE_TOP_MACROS_SVH

// Same-cycle implication under active-low reset.
`define HNPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hnpt assertion failed");

// Next-cycle implication under active-low reset.
`define HNPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hnpt assertion failed");

`endif

FILE: hw/rtl/hnpt_pkg.sv
package hnpt_pkg;

    typedef enum logic [1:0] {
        REQ_DISC = 2'd0,
        REQ_HB   = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        EV_IGNORED   = 3'd0,
        EV_STORED    = 3'd1,
        EV_FULL      = 3'd2,
        EV_ONLINE    = 3'd3,
        EV_TIMEOUT   = 3'd4,
        EV_SCAN_DONE = 3'd5
    } t_ev;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_TEMIT,
        ST_UPD,
        ST_DONE
    } t_state;

    // Register indexes (word address)
    localparam logic [2:0] REG_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_MASTER     = 3'd1;
    localparam logic [2:0] REG_BCAST      = 3'd2;
    localparam logic [2:0] REG_MOTOR_TYPE = 3'd3;
    localparam logic [2:0] REG_MOTOR_BASE = 3'd4;
    localparam logic [2:0] REG_MOTOR_CNT  = 3'd5;

    localparam logic [3:0] DISC_MIN_LEN = 4'd6;
    localparam logic [3:0] HB_MIN_LEN   = 4'd4;
    localparam logic [7:0] HB_HEALTHY   = 8'h00;

    typedef struct packed {
        logic [15:0] timeout;
        logic [7:0]  master;
        logic [7:0]  bcast;
        logic [7:0]  motor_type;
        logic [7:0]  motor_base;
        logic [7:0]  motor_cnt;
    } t_cfg;

    // details: hw 7..0, sw 23..8, capability 31..24, error 39..32, uptime 55..40
    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  dtype;
        logic [31:0] seen;
        logic [63:0] details;
    } t_entry;

endpackage

FILE: hw/rtl/hnpt_ram.sv
module hnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/hnpt_regs.sv
module hnpt_regs import hnpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // take a write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout    <= 16'd1500;
            r_cfg.master     <= 8'd0;
            r_cfg.bcast      <= 8'd127;
            r_cfg.motor_type <= 8'd1;
            r_cfg.motor_base <= 8'd16;
            r_cfg.motor_cnt  <= 8'd20;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TIMEOUT:    r_cfg.timeout    <= pwdata[15:0];
                REG_MASTER:     r_cfg.master     <= pwdata[7:0];
                REG_BCAST:      r_cfg.bcast      <= pwdata[7:0];
                REG_MOTOR_TYPE: r_cfg.motor_type <= pwdata[7:0];
                REG_MOTOR_BASE: r_cfg.motor_base <= pwdata[7:0];
                REG_MOTOR_CNT:  r_cfg.motor_cnt  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_TIMEOUT:    prdata = {16'd0, r_cfg.timeout};
            REG_MASTER:     prdata = {24'd0, r_cfg.master};
            REG_BCAST:      prdata = {24'd0, r_cfg.bcast};
            REG_MOTOR_TYPE: prdata = {24'd0, r_cfg.motor_type};
            REG_MOTOR_BASE: prdata = {24'd0, r_cfg.motor_base};
            REG_MOTOR_CNT:  prdata = {24'd0, r_cfg.motor_cnt};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

FILE: hw/rtl/heartbeat_node_presence_table_top.sv
// Node presence table for a field bus host. Each word on the input channel is a
// discovery response, a heartbeat or a timeout tick; each gives one or more
// result words, the final one flagged by o_last_result. Node records live in a
// single-port-read RAM, with valid and online bits in flops, so the block walks
// the slots one per cycle through that RAM read port; in a tick each timed-out
// node also passes through a report state, which waits while the output side
// stalls. One word is worked on at a time; a finished result may wait in the
// output register while the next word is taken. Registers sit on an APB port:
// 0 timeout (ms), 1 master address, 2 broadcast address, 3 motor type, 4 motor
// base address, 5 motor count, at byte addresses 4*index.
module heartbeat_node_presence_table_top import hnpt_pkg::*; #(
    parameter int NODE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_node_id,
    input  logic [3:0]  i_payload_len,
    input  logic [7:0]  i_dev_type_code,
    input  logic [7:0]  i_hw_version,
    input  logic [15:0] i_sw_version,
    input  logic        i_online_bit,
    input  logic [7:0]  i_capability_bits,
    input  logic [7:0]  i_hb_status,
    input  logic [7:0]  i_hb_error,
    input  logic [15:0] i_hb_uptime,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_event_node,
    output logic        o_stop_motor,
    output logic [6:0]  o_online_count,
    output logic        o_last_result
);
    localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NODE_SLOTS - 1);
    localparam int EW = $bits(t_entry);

    t_cfg   cfg;
    t_entry rd_ent;
    t_entry wr_ent;
    logic   ram_we;
    logic [IW-1:0] rd_addr;

    // control state
    t_state r_state, n_state;
    logic [NODE_SLOTS-1:0] r_valid, n_valid;
    logic [NODE_SLOTS-1:0] r_online, n_online;
    logic [6:0] r_count, n_count;
    logic r_ov, n_ov;

    // work registers
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_slot, n_slot;
    logic r_free_ok, n_free_ok;
    t_entry r_ent, n_ent;
    t_ev r_ev_code, n_ev_code;
    logic [7:0] r_ev_node, n_ev_node;
    logic r_ev_stop, n_ev_stop;

    // output word
    logic [2:0] r_oev, n_oev;
    logic [7:0] r_onode, n_onode;
    logic r_ostop, n_ostop;
    logic [6:0] r_ocnt, n_ocnt;
    logic r_olast, n_olast;

    // held input word
    t_req        r_req;
    logic [7:0]  r_node;
    logic [3:0]  r_len;
    logic [7:0]  r_dtype;
    logic [7:0]  r_hw;
    logic [15:0] r_sw;
    logic        r_onl;
    logic [7:0]  r_cap;
    logic [7:0]  r_st;
    logic [7:0]  r_err;
    logic [15:0] r_up;
    logic [31:0] r_now;

    logic in_acc;
    logic out_ld;
    logic filtered;
    logic hit_to;
    logic stop_calc;
    logic match;
    logic [31:0] age;
    logic [8:0] motor_end;
    logic new_on;

    hnpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hnpt_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (rd_ent)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_ld     = ~r_ov | i_out_ready;

    // slot checks on the word just read
    assign age       = r_now - rd_ent.seen;
    assign hit_to    = r_valid[r_idx] & r_online[r_idx] & (age > {16'd0, cfg.timeout});
    assign motor_end = {1'b0, cfg.motor_base} + {1'b0, cfg.motor_cnt};
    assign stop_calc = (rd_ent.dtype == cfg.motor_type)
                     && (rd_ent.addr >= cfg.motor_base)
                     && ({1'b0, rd_ent.addr} < motor_end);
    assign match     = r_valid[r_idx] && (rd_ent.addr == r_node);
    assign filtered  = (r_node == cfg.master) || (r_node == cfg.bcast)
                     || ((r_req == REQ_DISC) && (r_len < DISC_MIN_LEN))
                     || ((r_req == REQ_HB) && (r_len < HB_MIN_LEN));
    assign new_on    = (r_req == REQ_DISC) ? r_onl
                     : (r_online[r_slot] | (r_st == HB_HEALTHY));

    // read address: one slot ahead while scanning
    always_comb begin
        case (r_state)
            ST_SCAN, ST_TEMIT: rd_addr = r_idx + IW'(1);
            default:           rd_addr = '0;
        endcase
    end

    // new record for the slot being updated
    always_comb begin
        if (r_req == REQ_DISC) begin
            wr_ent = {r_node, r_dtype, r_now, r_ent.details[63:32], r_cap, r_sw, r_hw};
        end else begin
            wr_ent = {r_ent.addr, r_ent.dtype, r_now, r_ent.details[63:56],
                      r_up, r_err, r_ent.details[31:0]};
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_online  = r_online;
        n_count   = r_count;
        n_ov      = r_ov & ~i_out_ready;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_free_ok = r_free_ok;
        n_ent     = r_ent;
        n_ev_code = r_ev_code;
        n_ev_node = r_ev_node;
        n_ev_stop = r_ev_stop;
        n_oev     = r_oev;
        n_onode   = r_onode;
        n_ostop   = r_ostop;
        n_ocnt    = r_ocnt;
        n_olast   = r_olast;
        ram_we    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_START;
                end
            end

            // sort out filtered and unknown words, else start the walk
            ST_START: begin
                n_idx     = '0;
                n_free_ok = 1'b0;
                if (r_req == REQ_TICK) begin
                    n_state = ST_SCAN;
                end else if (r_req == REQ_NONE) begin
                    n_ev_code = EV_IGNORED;
                    n_ev_node = 8'd0;
                    n_state   = ST_DONE;
                end else if (filtered) begin
                    n_ev_code = EV_IGNORED;
                    n_ev_node = r_node;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (r_req == REQ_TICK) begin
                    if (hit_to) begin
                        n_ev_node = rd_ent.addr;
                        n_ev_stop = stop_calc;
                        n_state   = ST_TEMIT;
                    end else if (r_idx == LAST_IDX) begin
                        n_ev_code = EV_SCAN_DONE;
                        n_ev_node = 8'd0;
                        n_state   = ST_DONE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else if (match) begin
                    n_slot  = r_idx;
                    n_ent   = rd_ent;
                    n_state = ST_UPD;
                end else begin
                    // remember the lowest free slot
                    if (!r_valid[r_idx] && !r_free_ok) begin
                        n_slot    = r_idx;
                        n_free_ok = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        if ((r_req == REQ_DISC) && n_free_ok) begin
                            n_state = ST_UPD;
                        end else begin
                            n_ev_code = (r_req == REQ_DISC) ? EV_FULL : EV_IGNORED;
                            n_ev_node = r_node;
                            n_state   = ST_DONE;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            // report one timed-out node and drop it offline
            ST_TEMIT: begin
                if (out_ld) begin
                    n_online[r_idx] = 1'b0;
                    if (r_count != 7'd0) begin
                        n_count = r_count - 7'd1;
                    end
                    n_ov    = 1'b1;
                    n_oev   = EV_TIMEOUT;
                    n_onode = r_ev_node;
                    n_ostop = r_ev_stop;
                    n_ocnt  = n_count;
                    n_olast = 1'b0;
                    if (r_idx == LAST_IDX) begin
                        n_ev_code = EV_SCAN_DONE;
                        n_ev_node = 8'd0;
                        n_state   = ST_DONE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_SCAN;
                    end
                end
            end

            // write back the slot and report
            ST_UPD: begin
                if (out_ld) begin
                    ram_we          = 1'b1;
                    n_valid[r_slot] = 1'b1;
                    if (r_online[r_slot] && !new_on && (r_count != 7'd0)) begin
                        n_count = r_count - 7'd1;
                    end else if (!r_online[r_slot] && new_on) begin
                        n_count = r_count + 7'd1;
                    end
                    n_online[r_slot] = new_on;
                    n_ov    = 1'b1;
                    n_oev   = ((r_req == REQ_HB) && !r_online[r_slot] && new_on)
                              ? EV_ONLINE : EV_STORED;
                    n_onode = r_node;
                    n_ostop = 1'b0;
                    n_ocnt  = n_count;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            // final word of the item
            ST_DONE: begin
                if (out_ld) begin
                    n_ov    = 1'b1;
                    n_oev   = r_ev_code;
                    n_onode = r_ev_node;
                    n_ostop = 1'b0;
                    n_ocnt  = r_count;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_online <= '0;
            r_count  <= 7'd0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_online <= n_online;
            r_count  <= n_count;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_free_ok <= n_free_ok;
        r_ent     <= n_ent;
        r_ev_code <= n_ev_code;
        r_ev_node <= n_ev_node;
        r_ev_stop <= n_ev_stop;
        r_oev     <= n_oev;
        r_onode   <= n_onode;
        r_ostop   <= n_ostop;
        r_ocnt    <= n_ocnt;
        r_olast   <= n_olast;
        if (in_acc) begin
            r_req   <= t_req'(i_req_type);
            r_node  <= i_node_id;
            r_len   <= i_payload_len;
            r_dtype <= i_dev_type_code;
            r_hw    <= i_hw_version;
            r_sw    <= i_sw_version;
            r_onl   <= i_online_bit;
            r_cap   <= i_capability_bits;
            r_st    <= i_hb_status;
            r_err   <= i_hb_error;
            r_up    <= i_hb_uptime;
            r_now   <= i_now_ms;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_event_res    = r_oev;
    assign o_event_node   = r_onode;
    assign o_stop_motor   = r_ostop;
    assign o_online_count = r_ocnt;
    assign o_last_result  = r_olast;
endmodule

FILE: hw/rtl/hnpt_checker.sv
`include "heartbeat_node_presence_table_top_macros.svh"

module hnpt_checker import hnpt_pkg::*; #(
    parameter int NODE_SLOTS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_event_res,
    input logic [7:0]  o_event_node,
    input logic        o_stop_motor,
    input logic [6:0]  o_online_count,
    input logic        o_last_result
);
    // hold a stalled result word
    `HNPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // count never exceeds the table
    `HNPT_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_out_valid, o_online_count <= 7'(NODE_SLOTS))

    // motor stop only on a timeout word, which is never the last
    `HNPT_ASSERT_NOW(a_stop_timeout, i_clk, i_rst_n, o_out_valid && o_stop_motor, o_event_res == EV_TIMEOUT && !o_last_result)

    // scan done closes the item with node zero
    `HNPT_ASSERT_NOW(a_scan_done, i_clk, i_rst_n, o_out_valid && o_event_res == EV_SCAN_DONE, o_last_result && o_event_node == 8'd0)
endmodule

bind heartbeat_node_presence_table_top hnpt_checker #(.NODE_SLOTS(NODE_SLOTS)) u_hnpt_checker (.*);

FILE: dv/tb_heartbeat_node_presence_table_top.sv
`timescale 1ns / 1ps

module tb_heartbeat_node_presence_table_top;
    import hnpt_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_ev        ev;
        logic [7:0] node;
        logic       stop;
        logic [6:0] count;
        logic       last;
    } t_event_word;

    typedef struct {
        t_req        req;
        logic [7:0]  node;
        logic [3:0]  len;
        logic [7:0]  dtype;
        logic [7:0]  hw;
        logic [15:0] sw;
        logic        online;
        logic [7:0]  cap;
        logic [7:0]  status;
        logic [7:0]  err;
        logic [15:0] uptime;
        logic [31:0] now;
    } t_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_node_id = '0;
    logic [3:0]  i_payload_len = '0;
    logic [7:0]  i_dev_type_code = '0;
    logic [7:0]  i_hw_version = '0;
    logic [15:0] i_sw_version = '0;
    logic        i_online_bit = 1'b0;
    logic [7:0]  i_capability_bits = '0;
    logic [7:0]  i_hb_status = '0;
    logic [7:0]  i_hb_error = '0;
    logic [15:0] i_hb_uptime = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_event_node;
    logic        o_stop_motor;
    logic [6:0]  o_online_count;
    logic        o_last_result;

    heartbeat_node_presence_table_top dut (.*);

    always #2 i_clk = ~i_clk;

    // shadow table and register copy
    t_cfg        cfg;
    logic        tbl_valid  [SLOTS];
    logic        tbl_online [SLOTS];
    logic [7:0]  tbl_addr   [SLOTS];
    logic [7:0]  tbl_type   [SLOTS];
    logic [31:0] tbl_seen   [SLOTS];
    int          online_nodes;
    logic [31:0] clock_ms;

    t_event_word expected_events[$];
    int          errors;
    int          events_seen;
    int          frames_sent;
    int          cycles;
    logic        rx_stall_en;

    // pick a gap: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_event_word make_event(t_ev ev, logic [7:0] node, logic stop,
                                               logic last);
        t_event_word w;
        w.ev = ev;
        w.node = node;
        w.stop = stop;
        w.count = 7'(online_nodes);
        w.last = last;
        return w;
    endfunction

    task automatic mark_online(int s, logic on);
        if (tbl_online[s] && !on && online_nodes > 0) online_nodes--;
        else if (!tbl_online[s] && on) online_nodes++;
        tbl_online[s] = on;
    endtask

    function automatic int lookup_slot(logic [7:0] a);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_valid[s] && tbl_addr[s] == a) return s;
        return -1;
    endfunction

    // predict the event words caused by one frame
    task automatic predict_frame(t_frame f);
        int s;
        logic stop;
        s = -1;
        stop = 1'b0;
        if (f.req == REQ_TICK) begin
            for (int k = 0; k < SLOTS; k++) begin
                if (tbl_valid[k] && tbl_online[k] &&
                    (f.now - tbl_seen[k]) > {16'd0, cfg.timeout}) begin
                    stop = (tbl_type[k] == cfg.motor_type) &&
                           (tbl_addr[k] >= cfg.motor_base) &&
                           (9'(tbl_addr[k]) < 9'(cfg.motor_base) + 9'(cfg.motor_cnt));
                    mark_online(k, 1'b0);
                    expected_events.push_back(make_event(EV_TIMEOUT, tbl_addr[k], stop, 1'b0));
                end
            end
            expected_events.push_back(make_event(EV_SCAN_DONE, 8'd0, 1'b0, 1'b1));
        end else if (f.req == REQ_NONE) begin
            expected_events.push_back(make_event(EV_IGNORED, 8'd0, 1'b0, 1'b1));
        end else if (f.node == cfg.master || f.node == cfg.bcast ||
                     (f.req == REQ_DISC && f.len < DISC_MIN_LEN) ||
                     (f.req == REQ_HB && f.len < HB_MIN_LEN)) begin
            expected_events.push_back(make_event(EV_IGNORED, f.node, 1'b0, 1'b1));
        end else if (f.req == REQ_DISC) begin
            s = lookup_slot(f.node);
            if (s < 0) begin
                for (int k = 0; k < SLOTS; k++)
                    if (!tbl_valid[k]) begin
                        s = k;
                        break;
                    end
                if (s >= 0) begin
                    tbl_valid[s] = 1'b1;
                    tbl_addr[s] = f.node;
                    tbl_online[s] = 1'b0;
                end
            end
            if (s < 0) begin
                expected_events.push_back(make_event(EV_FULL, f.node, 1'b0, 1'b1));
            end else begin
                tbl_type[s] = f.dtype;
                tbl_seen[s] = f.now;
                mark_online(s, f.online);
                expected_events.push_back(make_event(EV_STORED, f.node, 1'b0, 1'b1));
            end
        end else begin
            s = lookup_slot(f.node);
            if (s < 0) begin
                expected_events.push_back(make_event(EV_IGNORED, f.node, 1'b0, 1'b1));
            end else begin
                tbl_seen[s] = f.now;
                if (!tbl_online[s] && f.status == HB_HEALTHY) begin
                    mark_online(s, 1'b1);
                    expected_events.push_back(make_event(EV_ONLINE, f.node, 1'b0, 1'b1));
                end else begin
                    expected_events.push_back(make_event(EV_STORED, f.node, 1'b0, 1'b1));
                end
            end
        end
    endtask

    // send one frame and record its expected events
    task automatic send_frame(t_frame f);
        int gap;
        gap = pick_gap();
        repeat (gap) @(posedge i_clk);
        predict_frame(f);
        i_in_valid        <= 1'b1;
        i_req_type        <= f.req;
        i_node_id         <= f.node;
        i_payload_len     <= f.len;
        i_dev_type_code   <= f.dtype;
        i_hw_version      <= f.hw;
        i_sw_version      <= f.sw;
        i_online_bit      <= f.online;
        i_capability_bits <= f.cap;
        i_hb_status       <= f.status;
        i_hb_error        <= f.err;
        i_hb_uptime       <= f.uptime;
        i_now_ms          <= f.now;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        // block is busy right after a word, so hold valid low before the next frame
        @(posedge i_clk);
        frames_sent++;
    endtask

    function automatic t_frame rand_frame(t_req req, logic [7:0] node);
        t_frame f;
        f.req = req;
        f.node = node;
        f.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        f.dtype = ($urandom_range(0, 1)) ? cfg.motor_type : 8'($urandom);
        f.hw = 8'($urandom);
        f.sw = 16'($urandom);
        f.online = 1'($urandom);
        f.cap = 8'($urandom);
        f.status = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
        f.err = 8'($urandom);
        f.uptime = 16'($urandom);
        f.now = clock_ms;
        return f;
    endfunction

    // wait until all events are back and the block has settled
    task automatic drain();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // return the bus to idle between transfers
        @(posedge i_clk);
        case (idx)
            REG_TIMEOUT:    cfg.timeout = val[15:0];
            REG_MASTER:     cfg.master = val[7:0];
            REG_BCAST:      cfg.bcast = val[7:0];
            REG_MOTOR_TYPE: cfg.motor_type = val[7:0];
            REG_MOTOR_BASE: cfg.motor_base = val[7:0];
            REG_MOTOR_CNT:  cfg.motor_cnt = val[7:0];
            default: ;
        endcase
    endtask

    // directed: filters, short frames, fill, full, heartbeats, timeouts, bad request
    task automatic test_directed();
        t_frame f;
        f = rand_frame(REQ_DISC, 8'h00);
        send_frame(f);
        f = rand_frame(REQ_HB, 8'd127);
        f.len = 4'd8;
        send_frame(f);
        f = rand_frame(REQ_DISC, 8'd20);
        f.len = 4'd5;
        send_frame(f);
        f = rand_frame(REQ_HB, 8'd20);
        f.len = 4'd3;
        send_frame(f);
        f = rand_frame(REQ_HB, 8'd200);
        f.len = 4'd4;
        send_frame(f);
        for (int k = 0; k < SLOTS + 1; k++) begin
            f = rand_frame(REQ_DISC, 8'(k + 10));
            f.len = (k == 0) ? 4'd6 : 4'd15;
            f.dtype = 8'h01;
            f.online = (k % 3 != 0);
            f.hw = 8'hFF;
            f.sw = 16'hFFFF;
            f.cap = 8'hFF;
            send_frame(f);
        end
        f = rand_frame(REQ_HB, 8'd10);
        f.status = 8'h00;
        f.len = 4'd4;
        send_frame(f);
        f = rand_frame(REQ_NONE, 8'hFF);
        send_frame(f);
        f = rand_frame(REQ_TICK, 8'h00);
        f.now = clock_ms + 32'd1500;
        send_frame(f);
        f = rand_frame(REQ_TICK, 8'h00);
        f.now = clock_ms + 32'd1501;
        send_frame(f);
        f = rand_frame(REQ_TICK, 8'h00);
        f.now = clock_ms - 32'd5;
        send_frame(f);
        drain();
    endtask

    // random traffic around a pool of node addresses with advancing time
    task automatic test_random(int n);
        t_frame f;
        logic [7:0] node;
        int r;
        for (int k = 0; k < n; k++) begin
            clock_ms += $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 600);
            r = $urandom_range(0, 99);
            node = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(8, 31));
            if (r < 35)      f = rand_frame(REQ_DISC, node);
            else if (r < 75) f = rand_frame(REQ_HB, node);
            else if (r < 95) f = rand_frame(REQ_TICK, 8'($urandom));
            else             f = rand_frame(REQ_NONE, 8'($urandom));
            send_frame(f);
        end
        drain();
    endtask

    // registers: extremes, then mid values
    task automatic test_config_sweep();
        write_reg(REG_TIMEOUT, 32'd0);
        write_reg(REG_MASTER, 32'd255);
        write_reg(REG_BCAST, 32'd0);
        write_reg(REG_MOTOR_TYPE, 32'd255);
        write_reg(REG_MOTOR_BASE, 32'd250);
        write_reg(REG_MOTOR_CNT, 32'd255);
        test_random(60);
        write_reg(REG_TIMEOUT, 32'd65535);
        write_reg(REG_MOTOR_TYPE, 32'd0);
        write_reg(REG_MOTOR_BASE, 32'd0);
        write_reg(REG_MOTOR_CNT, 32'd0);
        test_random(40);
        write_reg(REG_TIMEOUT, 32'd700);
        write_reg(REG_MASTER, 32'd9);
        write_reg(REG_BCAST, 32'd30);
        write_reg(REG_MOTOR_TYPE, 32'd1);
        write_reg(REG_MOTOR_BASE, 32'd12);
        write_reg(REG_MOTOR_CNT, 32'd8);
        test_random(60);
    endtask

    // check each event word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_event_word exp_w;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event ev=%0d node=%0d", $time, o_event_res,
                         o_event_node);
                errors++;
            end else begin
                exp_w = expected_events.pop_front();
                events_seen++;
                if (o_event_res !== exp_w.ev || o_event_node !== exp_w.node ||
                    o_stop_motor !== exp_w.stop || o_online_count !== exp_w.count ||
                    o_last_result !== exp_w.last)
                begin
                    $display("%0t: mismatch exp ev=%0d node=%0d stop=%0d cnt=%0d last=%0d",
                             $time, exp_w.ev, exp_w.node, exp_w.stop, exp_w.count, exp_w.last);
                    $display("%0t:          got ev=%0d node=%0d stop=%0d cnt=%0d last=%0d",
                             $time, o_event_res, o_event_node, o_stop_motor,
                             o_online_count, o_last_result);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, with stall-free stretches
    always @(posedge i_clk) begin
        if (!rx_stall_en) i_out_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 10) i_out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 3) i_out_ready <= ($urandom_range(0, 3) == 0);
        else i_out_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        errors = 0;
        events_seen = 0;
        frames_sent = 0;
        cycles = 0;
        online_nodes = 0;
        clock_ms = 32'd1000;
        rx_stall_en = 1'b1;
        cfg = '{timeout: 16'd1500, master: 8'd0, bcast: 8'd127, motor_type: 8'd1,
                motor_base: 8'd16, motor_cnt: 8'd20};
        for (int k = 0; k < SLOTS; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_online[k] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        rx_stall_en = 1'b0;
        test_random(40);
        rx_stall_en = 1'b1;
        test_config_sweep();
        $display("sent %0d frames, checked %0d events over several register settings",
                 frames_sent, events_seen);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d errors, %0d events missing", errors, expected_events.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
